FILE: design/two_class_alternating_arbiter_assert.svh
// ----------------------------------------------------------------------------
// two_class_alternating_arbiter_assert.svh
// Assertion macros shared by the arbiter's checker.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_ALTERNATING_ARBITER_ASSERT_SVH
`define TWO_CLASS_ALTERNATING_ARBITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TCA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tca: same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define TCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tca: next-cycle implication failed");

`endif

FILE: design/tca_pkg.sv
// ----------------------------------------------------------------------------
// tca_pkg
// Types and codes shared by the two-class alternating arbiter.
// ----------------------------------------------------------------------------
package tca_pkg;

  localparam int ID_W = 8;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic            kind;
    logic            category;
    logic [ID_W-1:0] requester_id;
  } in_word_t;

  typedef struct packed {
    logic            grant_valid;
    logic [ID_W-1:0] grant_id;
    logic            grant_category;
    logic            dropped;
    logic            busy_after;
  } out_word_t;

  // Commands from the arbiter to one class queue.
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  // Occupancy flags reported by one class queue.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

FILE: design/tca_cell.sv
// ----------------------------------------------------------------------------
// tca_cell
// One storage cell of a shifting queue: loads a new id or takes its neighbor's.
// ----------------------------------------------------------------------------
module tca_cell #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             load,
  input  logic             shift,
  input  logic [WIDTH-1:0] load_data,
  input  logic [WIDTH-1:0] neighbor_data,
  output logic [WIDTH-1:0] data
);

  // A write into this cell wins over a shift toward the head.
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= neighbor_data;
    end
  end

endmodule

FILE: design/tca_queue.sv
// ----------------------------------------------------------------------------
// tca_queue
// FIFO of waiting ids built as a row of cells; the head always sits in cell 0.
// ----------------------------------------------------------------------------
module tca_queue #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tca_pkg::queue_ctrl_t ctrl,
  input  logic [WIDTH-1:0]     push_data,
  output logic [WIDTH-1:0]     head,
  output tca_pkg::queue_stat_t stat
);
  import tca_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    fill;
  logic [WIDTH-1:0] cell_data [DEPTH];

  // A push lands in the first free cell; a pop moves every cell one place
  // toward the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] neighbor;
    if (i == DEPTH - 1) begin : g_last
      assign neighbor = '0;
    end else begin : g_mid
      assign neighbor = cell_data[i+1];
    end

    tca_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk          (clk),
      .load         (ctrl.push && (fill == CW'(i))),
      .shift        (ctrl.pop),
      .load_data    (push_data),
      .neighbor_data(neighbor),
      .data         (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctrl.push && !ctrl.pop) begin
      fill <= fill + CW'(1);
    end else if (ctrl.pop && !ctrl.push) begin
      fill <= fill - CW'(1);
    end
  end

  assign head       = cell_data[0];
  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == CW'(DEPTH));

endmodule

FILE: design/two_class_alternating_arbiter.sv
// ----------------------------------------------------------------------------
// two_class_alternating_arbiter
// Grants one shared resource to requesters of two classes, alternating classes
// on release.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle and returns exactly one result word
// for each, in the cycle after the word is accepted. A request that finds the
// resource free is granted at once; otherwise its id joins the queue of its
// class, or is dropped (dropped = 1) when that queue already holds QUEUE_DEPTH
// ids. A release hands the resource to the head of the other class's queue if
// there is one, else to the head of the holder's own class, else frees it; a
// release while the resource is free changes nothing and returns all zeros.
// Each queue is a row of cells with its head always in the first cell, so a
// grant reads a fixed place and a pop shifts the row by one in the same cycle.
// Results sit in an output register; a new word is accepted whenever that
// register is empty or is being read in the same cycle, so the sustained rate
// is one word per cycle and only a stalled result consumer slows the input.
// Ids are kept to the low ID_BITS bits of requester_id (at most eight bits).
// No clearing pass is needed after reset: the queues start empty by their fill
// counts, and a cell is only read after it has been written.
// ----------------------------------------------------------------------------
module two_class_alternating_arbiter #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  tca_pkg::in_word_t   item,
  output logic                result_valid,
  input  logic                result_ready,
  output tca_pkg::out_word_t  result
);
  import tca_pkg::*;

  // Stored id width: the port carries eight bits, so ID_BITS is capped at eight.
  localparam int IdWidth = (ID_BITS < ID_W) ? ID_BITS : ID_W;

  // Holder state.
  logic holder_active;
  logic holder_class;
  logic holder_active_next;
  logic holder_class_next;

  // Per-class queue interface, indexed by class.
  queue_ctrl_t        q_ctrl [2];
  queue_stat_t        q_stat [2];
  logic [IdWidth-1:0] q_head [2];
  logic [IdWidth-1:0] item_id;

  // Result being formed for the accepted word.
  out_word_t result_next;
  logic      accept;

  assign item_id    = item.requester_id[IdWidth-1:0];
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  for (genvar c = 0; c < 2; c++) begin : g_class
    tca_queue #(
      .DEPTH(QUEUE_DEPTH),
      .WIDTH(IdWidth)
    ) u_queue (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (q_ctrl[c]),
      .push_data(item_id),
      .head     (q_head[c]),
      .stat     (q_stat[c])
    );
  end

  // Arbitration decision for the word at the input. Queue commands are only
  // raised when the word is actually accepted.
  always_comb begin
    holder_active_next = holder_active;
    holder_class_next  = holder_class;
    result_next        = '0;
    q_ctrl[0]          = '0;
    q_ctrl[1]          = '0;

    if (item.kind == KIND_REQUEST) begin
      if (!holder_active) begin
        // Free resource: grant straight away.
        holder_active_next         = 1'b1;
        holder_class_next          = item.category;
        result_next.grant_valid    = 1'b1;
        result_next.grant_id       = ID_W'(item_id);
        result_next.grant_category = item.category;
      end else if (q_stat[item.category].full) begin
        result_next.dropped = 1'b1;
      end else begin
        q_ctrl[item.category].push = accept;
      end
    end else if (holder_active) begin
      // Release: the other class goes first, then the holder's own class.
      if (!q_stat[~holder_class].empty) begin
        q_ctrl[~holder_class].pop  = accept;
        holder_class_next          = ~holder_class;
        result_next.grant_valid    = 1'b1;
        result_next.grant_id       = ID_W'(q_head[~holder_class]);
        result_next.grant_category = ~holder_class;
      end else if (!q_stat[holder_class].empty) begin
        q_ctrl[holder_class].pop   = accept;
        result_next.grant_valid    = 1'b1;
        result_next.grant_id       = ID_W'(q_head[holder_class]);
        result_next.grant_category = holder_class;
      end else begin
        holder_active_next = 1'b0;
      end
    end

    result_next.busy_after = holder_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holder_active <= 1'b0;
      holder_class  <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (accept) begin
        holder_active <= holder_active_next;
        holder_class  <= holder_class_next;
        result_valid  <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is qualified by result_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

FILE: design/tca_checker.sv
// ----------------------------------------------------------------------------
// tca_checker
// Port-level checks for the two-class alternating arbiter, bound to the top.
// ----------------------------------------------------------------------------
`include "two_class_alternating_arbiter_assert.svh"

module tca_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input tca_pkg::in_word_t  item,
  input logic               result_valid,
  input logic               result_ready,
  input tca_pkg::out_word_t result
);
  import tca_pkg::*;

  // A stalled result word holds until it is taken.
  `TCA_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result))

  // Every accepted word yields a result in the next cycle.
  `TCA_ASSERT_NEXT(a_one_result, clk, rst, item_valid && item_ready, result_valid)

  // A grant always leaves the resource held.
  `TCA_ASSERT_IMPLY(a_grant_busy, clk, rst, result_valid && result.grant_valid, result.busy_after)

  // A drop only happens while the resource is held, and never with a grant.
  `TCA_ASSERT_IMPLY(a_drop_busy, clk, rst, result_valid && result.dropped, result.busy_after && !result.grant_valid)

endmodule

bind two_class_alternating_arbiter tca_checker u_tca_checker (.*);

FILE: sim/two_class_alternating_arbiter_checker.sv
// ----------------------------------------------------------------------------
// two_class_alternating_arbiter_checker
// Watches both channels of the arbiter, predicts each result word from the
// accepted input words and compares the two field by field.
// ----------------------------------------------------------------------------
module two_class_alternating_arbiter_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  tca_pkg::in_word_t  item,
  input  logic               result_valid,
  input  logic               result_ready,
  input  tca_pkg::out_word_t result,
  output int                 fail_count,
  output int                 pending,
  output int                 grants,
  output int                 drops
);

  timeunit 1ns;
  timeprecision 1ps;

  import tca_pkg::*;

  // Shadow of the arbiter: who holds the resource and the two waiting lines.
  logic            holder_on;
  logic            holder_cls;
  logic [ID_W-1:0] waiting_ids [2][QUEUE_DEPTH];
  int unsigned     waiting_head [2];
  int unsigned     waiting_fill [2];

  out_word_t       outcomes_due [$];
  out_word_t       want;
  int              words_in;
  int              words_out;

  assign pending = words_in - words_out;

  // Applies one input word to the shadow state and returns the result word.
  function automatic out_word_t arbitrate(input in_word_t w);
    out_word_t o;
    logic      cls;
    o = '0;
    if (w.kind == KIND_REQUEST) begin
      if (!holder_on) begin
        holder_on        = 1'b1;
        holder_cls       = w.category;
        o.grant_valid    = 1'b1;
        o.grant_id       = w.requester_id;
        o.grant_category = w.category;
      end else if (waiting_fill[w.category] == QUEUE_DEPTH) begin
        o.dropped = 1'b1;
      end else begin
        waiting_ids[w.category][(waiting_head[w.category] + waiting_fill[w.category])
                                % QUEUE_DEPTH] = w.requester_id;
        waiting_fill[w.category]++;
      end
    end else if (holder_on) begin
      // The other class goes first; the holder's own class only if the other is empty.
      cls = ~holder_cls;
      if (waiting_fill[cls] == 0) cls = holder_cls;
      if (waiting_fill[cls] == 0) begin
        holder_on = 1'b0;
      end else begin
        o.grant_valid      = 1'b1;
        o.grant_id         = waiting_ids[cls][waiting_head[cls]];
        o.grant_category   = cls;
        waiting_head[cls]  = (waiting_head[cls] + 1) % QUEUE_DEPTH;
        waiting_fill[cls]--;
        holder_cls         = cls;
      end
    end
    o.busy_after = holder_on;
    return o;
  endfunction

  task automatic report_word(input string what, input out_word_t exp_w, input out_word_t got);
    if (fail_count < 10)
      $display("checker: %s at result %0d: expected gv=%0b id=%02h cat=%0b drop=%0b busy=%0b,",
               what, words_out, exp_w.grant_valid, exp_w.grant_id, exp_w.grant_category,
               exp_w.dropped, exp_w.busy_after,
               " got gv=%0b id=%02h cat=%0b drop=%0b busy=%0b",
               got.grant_valid, got.grant_id, got.grant_category, got.dropped,
               got.busy_after);
    fail_count <= fail_count + 1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      holder_on    = 1'b0;
      holder_cls   = 1'b0;
      waiting_head = '{0, 0};
      waiting_fill = '{0, 0};
      outcomes_due.delete();
      words_in   <= 0;
      words_out  <= 0;
      fail_count <= 0;
      grants     <= 0;
      drops      <= 0;
    end else begin
      // Results are checked before the input of the same edge is predicted;
      // a word accepted now cannot have its result out in the same cycle.
      if (result_valid && result_ready) begin
        words_out <= words_out + 1;
        if (result.grant_valid === 1'b1) grants <= grants + 1;
        if (result.dropped === 1'b1) drops <= drops + 1;
        if (outcomes_due.size() == 0) begin
          report_word("unexpected word", '0, result);
        end else begin
          want = outcomes_due.pop_front();
          if (result.grant_valid !== want.grant_valid ||
              result.grant_id !== want.grant_id ||
              result.grant_category !== want.grant_category ||
              result.dropped !== want.dropped ||
              result.busy_after !== want.busy_after)
            report_word("mismatch", want, result);
        end
      end
      if (item_valid && item_ready) begin
        words_in <= words_in + 1;
        outcomes_due.push_back(arbitrate(item));
      end
    end
  end

endmodule

FILE: sim/two_class_alternating_arbiter_test.sv
// ----------------------------------------------------------------------------
// two_class_alternating_arbiter_test
// Drives request and release words into the arbiter with random idling on
// both channels, while a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
// A short directed part covers a release while the resource is free, a grant
// at once, a class 0 line filled to the brim and then overflowed, and the
// alternation between classes on release. The random part runs in phases that
// lean toward requests, releases or neither, and sometimes toward one class,
// so that both lines fill, overflow and drain again many times.
// ----------------------------------------------------------------------------
module two_class_alternating_arbiter_test;

  timeunit 1ns;
  timeprecision 1ps;

  import tca_pkg::*;

  localparam int WORD_COUNT  = 600;
  localparam int CYCLE_LIMIT = 200000;
  // The receiver holds off once for this many cycles, after this many results.
  localparam int HOLD_AT     = 150;
  localparam int HOLD_OFF    = 90;
  // The sender waits for every outstanding result once, after this many words.
  localparam int PAUSE_AT    = 400;

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      item_valid   = 1'b0;
  logic      item_ready;
  in_word_t  item         = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_word_t result;

  int fail_count;
  int pending;
  int grants;
  int drops;
  int cycles     = 0;
  int words_sent = 0;
  // When set, the sender offers words back to back with no idle cycles.
  bit sender_calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  two_class_alternating_arbiter DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  two_class_alternating_arbiter_checker watch (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending),
    .grants       (grants),
    .drops        (drops)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_word_t make_word(input logic kind, input logic category,
                                         input logic [ID_W-1:0] id);
    in_word_t w;
    w.kind         = kind;
    w.category     = category;
    w.requester_id = id;
    return w;
  endfunction

  // Offers one word after a random gap and returns at the edge that accepts it.
  // Valid is left high so that a following word with no gap keeps it high.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    words_sent++;
  endtask

  // Stops offering and waits until every predicted result has been returned.
  // One edge passes first so that the word accepted last is already counted.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: a random stall before each word, with calm stretches of no
  // stall at all, and one long hold-off that lets the block back up its input.
  initial begin
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      stall = calm ? 0 : $urandom_range(0, 19);
      if (taken == HOLD_AT) stall = HOLD_OFF;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      taken++;
    end
  end

  // Stimulus and verdict.
  initial begin
    int   phase_len;
    int   release_pct;
    int   lean;
    logic kind;
    logic cat;
    bit   paused;
    paused = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // A release with nobody holding the resource must change nothing.
    send_word(make_word(KIND_RELEASE, 1'b1, 8'hFF));
    // The resource is free, so this request is granted at once.
    send_word(make_word(KIND_REQUEST, 1'b0, 8'h00));
    // Fill the class 0 line completely; the next class 0 request is dropped.
    for (int i = 1; i <= 16; i++)
      send_word(make_word(KIND_REQUEST, 1'b0, 8'(i * 15)));
    send_word(make_word(KIND_REQUEST, 1'b0, 8'hAA));
    send_word(make_word(KIND_REQUEST, 1'b1, 8'hFF));
    // First release goes across to class 1, the second back to class 0, and
    // the third stays in class 0 because class 1 is empty by then.
    repeat (3) send_word(make_word(KIND_RELEASE, 1'b0, 8'h5A));
    wait_drained();

    // Random phases: each has its own mix of releases and its own class lean.
    while (words_sent < WORD_COUNT) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       release_pct = 20;
        1:       release_pct = 50;
        default: release_pct = 80;
      endcase
      lean        = $urandom_range(0, 2);
      sender_calm = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        if (!paused && words_sent >= PAUSE_AT) begin
          wait_drained();
          paused = 1'b1;
        end
        kind = ($urandom_range(0, 99) < release_pct) ? KIND_RELEASE : KIND_REQUEST;
        case (lean)
          0:       cat = 1'($urandom_range(0, 1));
          1:       cat = ($urandom_range(0, 9) == 0);
          default: cat = ($urandom_range(0, 9) != 0);
        endcase
        send_word(make_word(kind, cat, 8'($urandom_range(0, 255))));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("tb: covered %0d words with %0d grants and %0d dropped requests",
             words_sent, grants, drops);
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
